@@ rtl/tpd_pkg.sv @@
`timescale 1ns / 1ps

package tpd_pkg;

    // Width of the max_length configuration register and of the reported length.
    localparam int MAX_LEN_W = 10;
    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 10'd512;
    localparam logic [MAX_LEN_W-1:0] LEN_CAP = '1;

    // Payload size of an FEC packet.
    localparam int FEC_PAYLOAD_BYTES = 512;

    // Header geometry: a long header ends at byte 12, its payload CRC adds 4 more,
    // a short header (ACK/NACK) is 10 bytes in total.
    localparam int LONG_HDR_BYTES = 12;
    localparam int LONG_TAIL_BYTES = 16;
    localparam int SHORT_HDR_BYTES = 10;

    localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // First byte layout.
    localparam logic [7:0] TR_MASK = 8'b0010_0000;

    typedef enum logic [1:0] {
        PT_FEC  = 2'd0,
        PT_DATA = 2'd1,
        PT_ACK  = 2'd2,
        PT_NACK = 2'd3
    } pkt_type_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_CRC = 2'd1,
        ST_LEN = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_HEADER  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_PCRC    = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic                 is_payload;
        logic [7:0]           payload_byte;
        logic                 frame_done;
        status_t              status;
        logic [1:0]           pkt_type;
        logic                 truncated;
        logic [4:0]           window;
        logic [7:0]           seqnum;
        logic [MAX_LEN_W-1:0] payload_length;
        logic [31:0]          timestamp;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  ptype;
        logic        tr;
        logic [4:0]  window;
        logic [7:0]  seqnum;
        logic [15:0] len;
        logic [31:0] ts;
    } hdr_t;

    // Reflected CRC-32 update by one byte.
    function automatic logic [31:0] crc32_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/tpd_in_stage.sv @@
`timescale 1ns / 1ps

// Input register: holds one item until the parse stage takes it.
module tpd_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tpd_pkg::in_item_t in_item,
    input  logic              take,
    output logic              stg_valid,
    output tpd_pkg::in_item_t stg_item
);

    logic              valid_reg;
    tpd_pkg::in_item_t item_reg;

    assign in_ready  = !valid_reg || take;
    assign stg_valid = valid_reg;
    assign stg_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ rtl/tpd_parse_core.sv @@
`timescale 1ns / 1ps

// Per-byte parse step: header capture, CRC update, checks and result forming.
module tpd_parse_core #(
    parameter int FEC_PAYLOAD_BYTES = tpd_pkg::FEC_PAYLOAD_BYTES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           take,
    input  tpd_pkg::in_item_t              item,
    input  logic [tpd_pkg::MAX_LEN_W-1:0]  max_len,
    output logic                           res_valid,
    output tpd_pkg::out_item_t             res
);

    // Largest payload: the FEC size or the largest length max_length admits.
    localparam int PLEN_MAX = (FEC_PAYLOAD_BYTES > (2 ** tpd_pkg::MAX_LEN_W) - 1) ?
                              FEC_PAYLOAD_BYTES : (2 ** tpd_pkg::MAX_LEN_W) - 1;
    // The count saturates above every legal datagram length.
    localparam int CNT_W = $clog2(tpd_pkg::LONG_TAIL_BYTES + PLEN_MAX + 2);
    localparam int CMP_W = CNT_W + 1;
    localparam logic [CMP_W-1:0] FEC_BYTES = CMP_W'(FEC_PAYLOAD_BYTES);
    localparam logic [CMP_W-1:0] HDR_END = CMP_W'(tpd_pkg::LONG_HDR_BYTES);
    localparam logic [CMP_W-1:0] TAIL_END = CMP_W'(tpd_pkg::LONG_TAIL_BYTES);
    localparam logic [CMP_W-1:0] SHORT_END = CMP_W'(tpd_pkg::SHORT_HDR_BYTES);

    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    tpd_pkg::hdr_t           hdr_reg, hdr_next;
    logic [31:0]             crc_reg, crc_next;
    logic [31:0]             rcrc_reg, rcrc_next;
    tpd_pkg::status_t        err_reg, err_next;
    tpd_pkg::phase_t         ph_reg, ph_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            hdr_reg  <= '0;
            crc_reg  <= tpd_pkg::CRC_PRESET;
            rcrc_reg <= '0;
            err_reg  <= tpd_pkg::ST_OK;
            ph_reg   <= tpd_pkg::PH_FIRST;
        end
        else if (take)
        begin
            cnt_reg  <= cnt_next;
            hdr_reg  <= hdr_next;
            crc_reg  <= crc_next;
            rcrc_reg <= rcrc_next;
            err_reg  <= err_next;
            ph_reg   <= ph_next;
        end
    end

    always_comb
    begin
        logic [7:0]       b;
        logic             last;
        logic [CNT_W-1:0] pos;
        logic [CMP_W-1:0] pos1;
        logic [CMP_W-1:0] plen;
        logic [CMP_W-1:0] expected;
        logic             lng;
        logic [1:0]       ts_idx;

        b    = item.data_byte;
        last = item.last_byte;
        pos  = cnt_reg;
        pos1 = {1'b0, cnt_reg} + CMP_W'(1);

        cnt_next  = (cnt_reg == '1) ? cnt_reg : cnt_reg + CNT_W'(1);
        hdr_next  = hdr_reg;
        crc_next  = crc_reg;
        rcrc_next = rcrc_reg;
        err_next  = err_reg;
        ph_next   = ph_reg;
        res_valid = 1'b0;
        res       = '0;
        ts_idx    = 2'd0;
        plen      = '0;
        expected  = '0;
        lng       = 1'b0;

        unique case (ph_reg)
            tpd_pkg::PH_FIRST:
            begin
                hdr_next        = '0;
                hdr_next.ptype  = b[7:6];
                hdr_next.tr     = b[5];
                hdr_next.window = b[4:0];
                crc_next = tpd_pkg::crc32_byte(tpd_pkg::CRC_PRESET,
                                               !b[7] ? (b & ~tpd_pkg::TR_MASK) : b);
                ph_next  = tpd_pkg::PH_HEADER;
            end
            tpd_pkg::PH_HEADER:
            begin
                if (!hdr_reg.ptype[1])
                begin
                    // FEC / DATA: 12-byte header.
                    if (pos <= CNT_W'(7))
                    begin
                        crc_next = tpd_pkg::crc32_byte(crc_reg, b);
                    end
                    if (pos == CNT_W'(1))
                    begin
                        hdr_next.len[15:8] = b;
                    end
                    else if (pos == CNT_W'(2))
                    begin
                        hdr_next.len[7:0] = b;
                        if ({hdr_reg.len[15:8], b} > {6'd0, max_len} &&
                            err_next == tpd_pkg::ST_OK)
                        begin
                            err_next = tpd_pkg::ST_LEN;
                        end
                    end
                    else if (pos == CNT_W'(3))
                    begin
                        hdr_next.seqnum = b;
                    end
                    else if (pos >= CNT_W'(4) && pos <= CNT_W'(7))
                    begin
                        ts_idx = pos[1:0];
                        hdr_next.ts[8*ts_idx +: 8] = b;
                    end
                    else if (pos >= CNT_W'(8) && pos <= CNT_W'(11))
                    begin
                        rcrc_next = {rcrc_reg[23:0], b};
                    end
                    if (pos == CNT_W'(11))
                    begin
                        if ((crc_reg ^ tpd_pkg::CRC_PRESET) != rcrc_next &&
                            err_next == tpd_pkg::ST_OK)
                        begin
                            err_next = tpd_pkg::ST_CRC;
                        end
                        // A payload follows only when it has at least one byte; a DATA
                        // packet with a zero length field ends after its header.
                        if (!hdr_next.tr && hdr_next.len <= {6'd0, max_len} &&
                            (hdr_next.ptype == tpd_pkg::PT_FEC || hdr_next.len != '0))
                        begin
                            crc_next  = tpd_pkg::CRC_PRESET;
                            rcrc_next = '0;
                            ph_next   = tpd_pkg::PH_PAYLOAD;
                        end
                        else
                        begin
                            ph_next = tpd_pkg::PH_DONE;
                        end
                    end
                end
                else
                begin
                    // ACK / NACK: 6-byte header, CRC covers byte 0 as received.
                    if (pos <= CNT_W'(5))
                    begin
                        crc_next = tpd_pkg::crc32_byte(crc_reg, b);
                    end
                    if (pos == CNT_W'(1))
                    begin
                        hdr_next.seqnum = b;
                    end
                    else if (pos >= CNT_W'(2) && pos <= CNT_W'(5))
                    begin
                        ts_idx = pos[1:0] - 2'd2;
                        hdr_next.ts[8*ts_idx +: 8] = b;
                    end
                    else if (pos >= CNT_W'(6) && pos <= CNT_W'(9))
                    begin
                        rcrc_next = {rcrc_reg[23:0], b};
                    end
                    if (pos == CNT_W'(9))
                    begin
                        if ((crc_reg ^ tpd_pkg::CRC_PRESET) != rcrc_next &&
                            err_next == tpd_pkg::ST_OK)
                        begin
                            err_next = tpd_pkg::ST_CRC;
                        end
                        ph_next = tpd_pkg::PH_DONE;
                    end
                end
            end
            tpd_pkg::PH_PAYLOAD, tpd_pkg::PH_PCRC, tpd_pkg::PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        // Payload size as seen after this byte's header update.
        lng = !hdr_next.ptype[1];
        if (lng && !hdr_next.tr && hdr_next.len <= {6'd0, max_len})
        begin
            plen = (hdr_next.ptype == tpd_pkg::PT_FEC) ? FEC_BYTES : CMP_W'(hdr_next.len);
        end

        if (ph_reg == tpd_pkg::PH_PAYLOAD)
        begin
            crc_next = tpd_pkg::crc32_byte(crc_reg, b);
            if (pos1 >= HDR_END + plen)
            begin
                ph_next = tpd_pkg::PH_PCRC;
            end
            if (!last)
            begin
                res_valid        = 1'b1;
                res.is_payload   = 1'b1;
                res.payload_byte = b;
            end
        end
        else if (ph_reg == tpd_pkg::PH_PCRC)
        begin
            rcrc_next = {rcrc_reg[23:0], b};
            if (pos1 >= TAIL_END + plen)
            begin
                if ((crc_reg ^ tpd_pkg::CRC_PRESET) != rcrc_next &&
                    err_next == tpd_pkg::ST_OK)
                begin
                    err_next = tpd_pkg::ST_CRC;
                end
                ph_next = tpd_pkg::PH_DONE;
            end
        end

        if (last)
        begin
            if (!lng)
            begin
                expected = SHORT_END;
            end
            else if (plen != '0)
            begin
                expected = TAIL_END + plen;
            end
            else
            begin
                expected = HDR_END;
            end
            if (pos1 != expected && err_next == tpd_pkg::ST_OK)
            begin
                err_next = tpd_pkg::ST_LEN;
            end
            res_valid          = 1'b1;
            res.frame_done     = 1'b1;
            res.status         = err_next;
            res.pkt_type       = hdr_next.ptype;
            res.truncated      = hdr_next.tr;
            res.window         = hdr_next.window;
            res.seqnum         = hdr_next.seqnum;
            res.timestamp      = hdr_next.ts;
            if (lng)
            begin
                res.payload_length = (hdr_next.len > {6'd0, tpd_pkg::LEN_CAP}) ?
                                     tpd_pkg::LEN_CAP : hdr_next.len[tpd_pkg::MAX_LEN_W-1:0];
            end
            // Start the next datagram from a clean state.
            cnt_next  = '0;
            hdr_next  = '0;
            crc_next  = tpd_pkg::CRC_PRESET;
            rcrc_next = '0;
            err_next  = tpd_pkg::ST_OK;
            ph_next   = tpd_pkg::PH_FIRST;
        end
    end

endmodule

@@ rtl/tpd_out_stage.sv @@
`timescale 1ns / 1ps

// Result register: holds one result until the consumer takes it.
module tpd_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  tpd_pkg::out_item_t res,
    output logic               space,
    output logic               out_valid,
    input  logic               out_ready,
    output tpd_pkg::out_item_t out_item
);

    logic               valid_reg;
    tpd_pkg::out_item_t item_reg;

    assign space     = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (space)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (space && load)
        begin
            item_reg <= res;
        end
    end

endmodule

@@ rtl/transport_packet_deframer_crc_check_unit.sv @@
`timescale 1ns / 1ps

// An accepted item is held in the input register, then parsed into the output register.
// Throughput: one item per cycle while the consumer keeps up; bytes that give no result still
// take one pass of the parse stage. The pace is set by the single parse stage, which updates
// the CRC by a whole byte each cycle. Reset (rst_n, asynchronous, active low) empties both
// registers, restarts the parser at the first header byte and sets max_length to 512.
module transport_packet_deframer_crc_check_unit #(
    parameter int FEC_PAYLOAD_BYTES = tpd_pkg::FEC_PAYLOAD_BYTES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tpd_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tpd_pkg::out_item_t            out_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tpd_pkg::MAX_LEN_W-1:0] cfg_data
);

    // The configuration register can be written in any cycle.
    logic [tpd_pkg::MAX_LEN_W-1:0] max_len_reg;

    // Handshake between the stages. The parse stage consumes the held item whenever the
    // result register is free or is being emptied in the same cycle, so items flow every
    // cycle while the consumer keeps up.
    logic               stg_valid;
    tpd_pkg::in_item_t  stg_item;
    logic               space;
    logic               take;
    logic               res_valid;
    tpd_pkg::out_item_t res;

    assign cfg_ready = 1'b1;
    assign take      = stg_valid && space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= tpd_pkg::MAX_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_len_reg <= cfg_data;
        end
    end

    tpd_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .take      (take),
        .stg_valid (stg_valid),
        .stg_item  (stg_item)
    );

    // The parse stage keeps the per-datagram state: byte count, header fields, running and
    // received CRC, first error and parse phase. A payload byte yields a payload item as it
    // passes; the byte flagged last yields the final item with the header and the status.
    tpd_parse_core #(
        .FEC_PAYLOAD_BYTES (FEC_PAYLOAD_BYTES)
    ) u_parse_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (stg_item),
        .max_len   (max_len_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    tpd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && res_valid),
        .res       (res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
